/* sv/pkhm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pkhm_pkg;
    localparam int NUM_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int KEY_BITS     = 16;
    localparam int VALUE_BITS   = 32;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int CNT_W        = 9;
    localparam int SUM_W        = KEY_BITS + 1;
    localparam int SUM_CNT_W    = $clog2(SUM_W + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_ENTRIES);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_MOD, S_HEAD, S_HEAD_WAIT, S_WALK, S_WALK_WAIT,
        S_INS_POP, S_INS_WAIT, S_INS_LINK, S_REM_WAIT, S_REM_FIX, S_OUT
    } t_state;
endpackage
`default_nettype wire

/* sv/pkhm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pkhm_in_if;
    import pkhm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [KEY_BITS-1:0]   key_x;
    logic [KEY_BITS-1:0]   key_y;
    logic [VALUE_BITS-1:0] value_in;
    modport source (output valid, opcode, key_x, key_y, value_in, input ready);
    modport sink   (input valid, opcode, key_x, key_y, value_in, output ready);
endinterface

interface pkhm_out_if;
    import pkhm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] value_out;
    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface
`default_nettype wire

/* sv/pair_key_chained_hash_map_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pair-keyed chained hash map.
// Input channel (i_cmd): opcode, key_x, key_y, value_in; one item at a time.
// Output channel (o_rsp): status and value_out, one item per input item.
// APB port: register 0 (byte address 0) is bucket_count, 9 bits; 0 acts as 1,
// values above 256 act as 256. Write it only while the block is idle.
// The bucket index (x+y) mod count is found by a bit-serial restoring
// reduction. Insert then takes a pool entry and links it at the chain tail;
// lookup and remove read the bucket head and walk the chain (one
// synchronous read of the pool memory per entry visited); a remove then unlinks and frees the entry.
// Bucket heads sit in a memory; after reset a clearing pass writes every head
// empty, one bucket a cycle, and no item is taken meanwhile.
// The result waits in an output register; the block takes no new item until
// that result has been accepted, so a stalled receiver holds the block.
module pair_key_chained_hash_map_core
    import pkhm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    pkhm_in_if.sink    i_cmd,
    pkhm_out_if.source o_rsp,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [1:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    // memories
    logic [LINK_W-1:0]     m_head [NUM_BUCKETS];
    logic [IDX_W-1:0]      m_tail [NUM_BUCKETS];
    logic [KEY_BITS-1:0]   m_kx   [POOL_ENTRIES];
    logic [KEY_BITS-1:0]   m_ky   [POOL_ENTRIES];
    logic [VALUE_BITS-1:0] m_val  [POOL_ENTRIES];
    logic [LINK_W-1:0]     m_next [POOL_ENTRIES];

    t_state r_state, n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_kx, r_ky;
    logic [VALUE_BITS-1:0] r_v;
    logic [SUM_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_CNT_W-1:0]  r_bit;
    logic [BKT_W-1:0]      r_bkt;
    logic [BKT_W-1:0]      r_clr;
    logic [LINK_W-1:0]     r_cur, r_prev, r_free, r_unused, r_new;
    logic [LINK_W-1:0]     r_head_q;
    logic [IDX_W-1:0]      r_tail_q;
    logic [KEY_BITS-1:0]   r_ex_q, r_ey_q;
    logic [VALUE_BITS-1:0] r_ev_q;
    logic [LINK_W-1:0]     r_en_q;
    logic [1:0]            r_status;
    logic [VALUE_BITS-1:0] r_vout;

    // effective modulus
    logic [CNT_W-1:0] w_mod;
    always_comb begin
        w_mod = r_cnt;
        if (r_cnt == '0) w_mod = CNT_W'(1);
        if (r_cnt > CNT_W'(NUM_BUCKETS)) w_mod = CNT_W'(NUM_BUCKETS);
    end

    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign pready = 1'b1;
    assign prdata = (paddr == 2'b00) ? {{(32-CNT_W){1'b0}}, r_cnt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= CNT_W'(256);
        else if (w_cfg_wr && paddr[1:0] == {1'b0, REG_BUCKET_COUNT}) r_cnt <= pwdata[CNT_W-1:0];
    end

    // restoring reduction step: shift in one sum bit per cycle
    logic [SUM_W:0] w_sh;
    assign w_sh = {r_rem, r_sum[SUM_W-1]};

    logic w_match, w_have_free, w_can_take, w_tail_is_cur;
    assign w_match       = (r_ex_q == r_kx) && (r_ey_q == r_ky);
    assign w_have_free   = r_free < LINK_NONE;
    assign w_can_take    = w_have_free || (r_unused < LINK_NONE);
    assign w_tail_is_cur = r_head_q < LINK_NONE;

    logic [IDX_W-1:0] w_cur_i;
    assign w_cur_i = r_cur[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == BKT_W'(NUM_BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_cmd.valid) n_state = S_MOD;
            S_MOD:   if (r_bit == SUM_CNT_W'(1)) n_state = S_HEAD;
            S_HEAD:  n_state = S_HEAD_WAIT;
            S_HEAD_WAIT: begin
                if (r_op == OP_INSERT) n_state = w_can_take ? S_INS_POP : S_OUT;
                else if (r_op == OP_LOOKUP || r_op == OP_REMOVE)
                    n_state = (r_head_q < LINK_NONE) ? S_WALK : S_OUT;
                else n_state = S_OUT;
            end
            S_WALK:      n_state = S_WALK_WAIT;
            S_WALK_WAIT: begin
                if (w_match) n_state = (r_op == OP_REMOVE) ? S_REM_WAIT : S_OUT;
                else if (r_en_q < LINK_NONE) n_state = S_WALK;
                else n_state = S_OUT;
            end
            S_INS_POP:  n_state = S_INS_WAIT;
            S_INS_WAIT: n_state = S_INS_LINK;
            S_INS_LINK: n_state = S_OUT;
            S_REM_WAIT: n_state = S_REM_FIX;
            S_REM_FIX:  n_state = S_OUT;
            S_OUT:      if (o_rsp.ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_cmd.ready     = (r_state == S_IDLE);
        o_rsp.valid     = (r_state == S_OUT);
        o_rsp.status    = r_status;
        o_rsp.value_out = r_vout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    // datapath and memory access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_free   <= LINK_NONE;
            r_unused <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    m_head[r_clr] <= LINK_NONE;
                    r_clr <= r_clr + BKT_W'(1);
                end
                S_IDLE: if (i_cmd.valid) begin
                    r_op     <= i_cmd.opcode;
                    r_kx     <= i_cmd.key_x;
                    r_ky     <= i_cmd.key_y;
                    r_v      <= i_cmd.value_in;
                    r_sum    <= SUM_W'(i_cmd.key_x) + SUM_W'(i_cmd.key_y);
                    r_rem    <= '0;
                    r_bit    <= SUM_CNT_W'(SUM_W);
                    r_status <= ST_NOT_FOUND;
                    r_vout   <= '0;
                end
                S_MOD: begin
                    if (w_sh >= (SUM_W+1)'(w_mod))
                        r_rem <= SUM_W'(w_sh - (SUM_W+1)'(w_mod));
                    else
                        r_rem <= w_sh[SUM_W-1:0];
                    r_sum <= r_sum << 1;
                    r_bit <= r_bit - SUM_CNT_W'(1);
                end
                S_HEAD: begin
                    r_bkt    <= r_rem[BKT_W-1:0];
                    r_head_q <= m_head[r_rem[BKT_W-1:0]];
                    r_tail_q <= m_tail[r_rem[BKT_W-1:0]];
                end
                S_HEAD_WAIT: begin
                    r_cur  <= r_head_q;
                    r_prev <= LINK_NONE;
                    if (r_op == OP_INSERT && !w_can_take) r_status <= ST_FULL;
                end
                S_WALK: begin
                    r_ex_q <= m_kx[w_cur_i];
                    r_ey_q <= m_ky[w_cur_i];
                    r_ev_q <= m_val[w_cur_i];
                    r_en_q <= m_next[w_cur_i];
                end
                S_WALK_WAIT: begin
                    if (w_match) begin
                        r_status <= ST_OK;
                        if (r_op == OP_LOOKUP) r_vout <= r_ev_q;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= r_en_q;
                    end
                end
                S_INS_POP: begin
                    // take a free-list entry if any, else a never-used one
                    if (w_have_free) begin
                        r_new  <= r_free;
                        r_en_q <= m_next[r_free[IDX_W-1:0]];
                    end else begin
                        r_new    <= r_unused;
                        r_unused <= r_unused + LINK_W'(1);
                    end
                end
                S_INS_WAIT: begin
                    if (w_have_free) r_free <= r_en_q;
                end
                S_INS_LINK: begin
                    m_kx[r_new[IDX_W-1:0]]   <= r_kx;
                    m_ky[r_new[IDX_W-1:0]]   <= r_ky;
                    m_val[r_new[IDX_W-1:0]]  <= r_v;
                    m_next[r_new[IDX_W-1:0]] <= LINK_NONE;
                    if (w_tail_is_cur) m_next[r_tail_q] <= r_new;
                    else m_head[r_bkt] <= r_new;
                    m_tail[r_bkt] <= r_new[IDX_W-1:0];
                    r_status <= ST_OK;
                end
                S_REM_WAIT: begin
                    // unlink the match from its predecessor or the head
                    if (r_prev < LINK_NONE) m_next[r_prev[IDX_W-1:0]] <= r_en_q;
                    else m_head[r_bkt] <= r_en_q;
                end
                S_REM_FIX: begin
                    if ({1'b0, r_tail_q} == r_cur)
                        m_tail[r_bkt] <= (r_prev < LINK_NONE) ? r_prev[IDX_W-1:0] : '0;
                    m_next[w_cur_i] <= r_free;
                    r_free <= r_cur;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/sv/tb_pair_key_chained_hash_map_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_pair_key_chained_hash_map_core;
    import pkhm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pkhm_in_if  cmd_if ();
    pkhm_out_if rsp_if ();

    pair_key_chained_hash_map_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Expected response: status and value.
    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] value;
    } t_rsp;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [KEY_BITS-1:0]   kx;
        logic [KEY_BITS-1:0]   ky;
        logic [VALUE_BITS-1:0] value;
        logic                  fixed;
        logic [1:0]            exp_status;
        logic [VALUE_BITS-1:0] exp_value;
    } t_row;

    // Shadow copy of the map.
    logic [CNT_W-1:0]      map_count;
    logic [LINK_W-1:0]     map_head [NUM_BUCKETS];
    logic [IDX_W-1:0]      map_tail [NUM_BUCKETS];
    logic [KEY_BITS-1:0]   pool_kx  [POOL_ENTRIES];
    logic [KEY_BITS-1:0]   pool_ky  [POOL_ENTRIES];
    logic [VALUE_BITS-1:0] pool_val [POOL_ENTRIES];
    logic [LINK_W-1:0]     pool_next[POOL_ENTRIES];
    logic [LINK_W-1:0]     free_top;
    int unsigned           fresh_cnt;

    t_rsp        pending_rsp[$];
    int unsigned bad_cnt;
    int unsigned cycle_cnt;

    function automatic int unsigned hash_bucket(logic [KEY_BITS-1:0] kx,
                                                logic [KEY_BITS-1:0] ky);
        int unsigned n;
        n = map_count;
        if (n == 0) n = 1;
        if (n > NUM_BUCKETS) n = NUM_BUCKETS;
        return (int'(kx) + int'(ky)) % n;
    endfunction

    // Apply one command to the shadow map and return the response it yields.
    function automatic t_rsp map_apply(logic [1:0] op, logic [KEY_BITS-1:0] kx,
                                       logic [KEY_BITS-1:0] ky,
                                       logic [VALUE_BITS-1:0] v);
        t_rsp        r;
        int unsigned b;
        int unsigned e;
        int unsigned cur;
        int unsigned prv;
        b = hash_bucket(kx, ky);
        r.status = ST_NOT_FOUND;
        r.value = '0;
        if (op == OP_INSERT) begin
            e = POOL_ENTRIES;
            if (free_top < LINK_NONE) begin
                e = free_top;
                free_top = pool_next[e];
            end else if (fresh_cnt < POOL_ENTRIES) begin
                e = fresh_cnt;
                fresh_cnt++;
            end
            if (e < POOL_ENTRIES) begin
                pool_kx[e] = kx;
                pool_ky[e] = ky;
                pool_val[e] = v;
                pool_next[e] = LINK_NONE;
                if (map_head[b] < LINK_NONE) pool_next[map_tail[b]] = LINK_W'(e);
                else map_head[b] = LINK_W'(e);
                map_tail[b] = IDX_W'(e);
                r.status = ST_OK;
            end else begin
                r.status = ST_FULL;
            end
        end else if (op == OP_LOOKUP || op == OP_REMOVE) begin
            prv = POOL_ENTRIES;
            cur = map_head[b];
            while (cur < POOL_ENTRIES) begin
                if (pool_kx[cur] == kx && pool_ky[cur] == ky) begin
                    r.status = ST_OK;
                    if (op == OP_LOOKUP) begin
                        r.value = pool_val[cur];
                    end else begin
                        if (prv < POOL_ENTRIES) pool_next[prv] = pool_next[cur];
                        else map_head[b] = pool_next[cur];
                        if (map_tail[b] == cur)
                            map_tail[b] = (prv < POOL_ENTRIES) ? IDX_W'(prv) : '0;
                        pool_next[cur] = free_top;
                        free_top = LINK_W'(cur);
                    end
                    break;
                end
                prv = cur;
                cur = pool_next[cur];
            end
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Count cycles; give up at a generous limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3_000_000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall per item, compare against the oldest expectation.
    initial begin
        int unsigned gap;
        t_rsp        want;
        rsp_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk iff rsp_if.valid);
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected item status=%0d value=%h", $time,
                         rsp_if.status, rsp_if.value_out);
                bad_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_if.status);
                    bad_cnt++;
                end
                if (rsp_if.value_out !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time,
                             want.value, rsp_if.value_out);
                    bad_cnt++;
                end
            end
        end
    end

    task automatic reg_write(logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_BUCKET_COUNT) << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        map_count = data[CNT_W-1:0];
    endtask

    // Send one command, predict its response, honor a random gap first.
    task automatic send_cmd(logic [1:0] op, logic [KEY_BITS-1:0] kx,
                            logic [KEY_BITS-1:0] ky, logic [VALUE_BITS-1:0] v,
                            logic fixed, t_rsp fixed_rsp);
        int unsigned gap;
        t_rsp        r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.key_x    <= kx;
        cmd_if.key_y    <= ky;
        cmd_if.value_in <= v;
        @(posedge i_clk iff cmd_if.ready);
        r = map_apply(op, kx, ky, v);
        if (fixed && r !== fixed_rsp)
            $display("%0t: table row disagrees with predictor", $time);
        pending_rsp.push_back(fixed ? fixed_rsp : r);
    endtask

    // Let the block drain before a register write.
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        cmd_if.valid <= 1'b0;
        while (pending_rsp.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        t_row          rows[$];
        t_row          row;
        t_rsp          fx;
        int unsigned   phase;
        int unsigned   k;
        int unsigned   bursts;
        logic [KEY_BITS-1:0] kx_set[16];
        logic [KEY_BITS-1:0] ky_set[16];
        logic [1:0]    op;
        int unsigned   pick;
        logic [CNT_W-1:0] counts[6];

        bad_cnt = 0;
        cycle_cnt = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = OP_INSERT;
        cmd_if.key_x = '0;
        cmd_if.key_y = '0;
        cmd_if.value_in = '0;
        map_count = CNT_W'(NUM_BUCKETS);
        for (k = 0; k < NUM_BUCKETS; k++) begin
            map_head[k] = LINK_NONE;
            map_tail[k] = '0;
        end
        free_top = LINK_NONE;
        fresh_cnt = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: {op, x, y, value, fixed, status, value}.
        rows = '{
            '{OP_LOOKUP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0},
            '{OP_REMOVE, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0},
            '{OP_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1, ST_OK, 32'hFFFFFFFF},
            '{OP_INSERT, 16'h0000, 16'h0000, 32'h00000000, 1'b1, ST_OK, 32'h0},
            '{OP_INSERT, 16'h0000, 16'h0000, 32'h5A5A5A5A, 1'b1, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_OK, 32'h0},
            '{OP_REMOVE, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_OK, 32'h5A5A5A5A},
            '{2'd3,      16'h1234, 16'h4321, 32'hDEADBEEF, 1'b1, ST_NOT_FOUND, 32'h0},
            '{OP_INSERT, 16'h0100, 16'h0000, 32'hA5A5A5A5, 1'b0, ST_OK, 32'h0},
            '{OP_INSERT, 16'h0000, 16'h0100, 32'h3C3C3C3C, 1'b0, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'h0100, 16'h0000, 32'h0, 1'b0, ST_OK, 32'h0},
            '{OP_REMOVE, 16'h0100, 16'h0000, 32'h0, 1'b0, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'h0000, 16'h0100, 32'h0, 1'b0, ST_OK, 32'h0},
            '{OP_INSERT, 16'h8000, 16'h8000, 32'h12345678, 1'b0, ST_OK, 32'h0},
            '{OP_LOOKUP, 16'h8000, 16'h7FFF, 32'h0, 1'b0, ST_OK, 32'h0},
            '{OP_REMOVE, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0, ST_OK, 32'h0}
        };
        @(posedge i_clk iff i_rst_n);
        foreach (rows[i]) begin
            row = rows[i];
            fx.status = row.exp_status;
            fx.value  = row.exp_value;
            send_cmd(row.opcode, row.kx, row.ky, row.value, row.fixed, fx);
        end

        // Random phases over several bucket counts, the extremes included.
        counts = '{9'd0, 9'd1, 9'd3, 9'd256, 9'd511, 9'd77};
        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            reg_write({23'd0, counts[phase]});
            // Small key sets so that lookups and removes mostly hit.
            for (k = 0; k < 16; k++) begin
                kx_set[k] = 16'($urandom);
                ky_set[k] = ($urandom_range(0, 1) == 0) ? kx_set[k] : 16'($urandom);
            end
            kx_set[0] = 16'hFFFF;
            ky_set[1] = 16'h0000;
            for (k = 0; k < 50; k++) begin
                pick = $urandom_range(0, 15);
                op = 2'($urandom_range(0, 9) < 4 ? OP_INSERT
                        : ($urandom_range(0, 1) ? OP_LOOKUP : OP_REMOVE));
                if ($urandom_range(0, 19) == 0) op = 2'($urandom);
                if ($urandom_range(0, 9) == 0)
                    send_cmd(op, 16'($urandom), 16'($urandom), $urandom, 1'b0, fx);
                else
                    send_cmd(op, kx_set[pick], ky_set[pick], $urandom, 1'b0, fx);
            end
        end

        // Fill the pool to reach the full status, then drain part of it.
        wait_idle();
        reg_write(32'd256);
        bursts = 0;
        while (fresh_cnt < POOL_ENTRIES || free_top < LINK_NONE) begin
            send_cmd(OP_INSERT, 16'(bursts), 16'(bursts >> 3), $urandom, 1'b0, fx);
            bursts++;
        end
        for (k = 0; k < 8; k++) begin
            send_cmd(OP_INSERT, 16'(bursts), 16'(bursts >> 3), $urandom, 1'b0, fx);
            bursts++;
        end
        for (k = 0; k < 20; k++)
            send_cmd(OP_REMOVE, 16'(k), 16'(k >> 3), '0, 1'b0, fx);
        for (k = 0; k < 25; k++)
            send_cmd(OP_INSERT, 16'($urandom), 16'($urandom), $urandom, 1'b0, fx);
        cmd_if.valid <= 1'b0;

        // Drain the response queue, then wait on for stray items.
        k = 0;
        while (pending_rsp.size() != 0 && k < 500_000) begin
            @(posedge i_clk);
            k++;
        end
        if (pending_rsp.size() != 0) begin
            $display("Mismatches found");
            $finish;
        end
        repeat (200) @(posedge i_clk);
        if (bad_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
sv/pkhm_pkg.sv
sv/pkhm_if.sv
sv/pair_key_chained_hash_map_core.sv
tb/sv/tb_pair_key_chained_hash_map_core.sv
